// File: rtl/load_cell_weight_filter_defines.svh
// Assertion macros used by the filter datapath module lcwf_dp
`ifndef LOAD_CELL_WEIGHT_FILTER_DEFINES_SVH
`define LOAD_CELL_WEIGHT_FILTER_DEFINES_SVH

`define LCWF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lcwf check failed");

`define LCWF_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lcwf reset check failed");

`endif

// File: rtl/lcwf_pkg.sv
package lcwf_pkg;

  typedef enum logic [2:0] {
    CfgMotionThr  = 3'd0,
    CfgStableThr  = 3'd1,
    CfgStableCnt  = 3'd2,
    CfgZeroBand   = 3'd3,
    CfgMaxWeight  = 3'd4,
    CfgMotionHold = 3'd5,
    CfgAgreeBand  = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    QualStabilizing = 2'd0,
    QualStable      = 2'd1,
    QualMotion      = 2'd2,
    QualError       = 2'd3
  } quality_t;

  typedef struct packed {
    logic [19:0] motion_thr;
    logic [19:0] settle_thr;
    logic [3:0]  stable_count_required;
    logic [19:0] zero_band;
    logic [23:0] max_weight;
    logic [15:0] motion_hold_ms;
    logic [19:0] agree_band;
  } cfg_t;

  typedef struct packed {
    logic cmd;
    logic sample_valid;
    logic signed [24:0] raw_weight;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [23:0] filtered_weight;
    logic signed [24:0] stable_weight;
    logic is_stable;
    logic has_motion;
    logic [1:0] quality;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic tare;
    logic error;
    logic sort_start;
    logic sort_step;
    logic div_start;
    logic div_step;
    logic finish;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sort_done;
    logic div_done;
  } dp_stat_t;

endpackage

// File: rtl/lcwf_if.sv
interface lcwf_if #(
  parameter int unsigned W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/lcwf_ctrl.sv
module lcwf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_cmd,
  input  logic                in_sample_valid,
  output logic                in_ready,
  input  logic                out_busy,
  output lcwf_pkg::dp_cmd_t   cmd,
  input  lcwf_pkg::dp_stat_t  stat
);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StSort = 5'b00010,
    StDiv  = 5'b00100,
    StFin  = 5'b01000,
    StWait = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      StIdle: begin
        in_ready = !out_busy;
        if (in_valid && !out_busy) begin
          if (in_cmd) begin
            cmd.tare = 1'b1;
          end else if (!in_sample_valid) begin
            cmd.error = 1'b1;
          end else begin
            cmd.load = 1'b1;
            state_nxt = StSort;
          end
        end
      end
      StSort: begin
        if (stat.sort_done) begin
          cmd.div_start = 1'b1;
          state_nxt = StDiv;
        end else begin
          cmd.sort_step = 1'b1;
        end
      end
      StDiv: begin
        if (stat.div_done) begin
          state_nxt = StWait;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      StWait: begin
        if (!out_busy) begin
          state_nxt = StFin;
        end
      end
      StFin: begin
        cmd.finish = 1'b1;
        state_nxt = StIdle;
      end
      default: state_nxt = StIdle;
    endcase
    cmd.sort_start = cmd.load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/lcwf_dp.sv
`include "load_cell_weight_filter_defines.svh"
module lcwf_dp #(
  parameter int unsigned RING_DEPTH = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lcwf_pkg::cfg_t      cfg,
  input  lcwf_pkg::in_item_t  item,
  input  lcwf_pkg::dp_cmd_t   cmd,
  output lcwf_pkg::dp_stat_t  stat,
  output logic                res_valid,
  output lcwf_pkg::out_item_t res,
  input  logic                res_taken
);

  localparam int unsigned IdxW = $clog2(RING_DEPTH);
  localparam int unsigned CntW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SW = 25 + CntW;
  localparam int unsigned DW = $clog2(SW + 1);

  logic signed [24:0] ring_r [RING_DEPTH];
  logic signed [24:0] srt_r [RING_DEPTH];
  logic [IdxW-1:0] widx_r;
  logic ring_full_r;
  logic [7:0] close_r;
  logic signed [24:0] last_stable_r, prev_r;
  logic [31:0] last_mt_r;
  logic motion_r;
  logic [31:0] now_r;
  logic [CntW-1:0] n_r, pass_r;
  logic signed [SW-1:0] sum_r;
  logic [SW-1:0] rem_r, quo_r;
  logic neg_r;
  logic [DW-1:0] dstep_r;
  logic signed [26:0] med_r, f_r;

  logic [CntW-1:0] n_new;
  logic [IdxW-1:0] widx_inc;
  logic wrap;

  assign wrap = (widx_r == IdxW'(RING_DEPTH - 1));
  assign widx_inc = wrap ? '0 : widx_r + 1'b1;
  assign n_new = (ring_full_r || wrap) ? CntW'(RING_DEPTH) : CntW'(widx_r) + 1'b1;

  // one odd-even transposition pass per cycle
  logic signed [24:0] srt_nxt [RING_DEPTH];
  always_comb begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      srt_nxt[i] = srt_r[i];
    end
    for (int i = 0; i + 1 < RING_DEPTH; i++) begin
      if ((i % 2) == int'(pass_r[0]) && (i + 1) < int'(n_r) &&
          srt_r[i] > srt_r[i+1]) begin
        srt_nxt[i] = srt_r[i+1];
        srt_nxt[i+1] = srt_r[i];
      end
    end
  end

  assign stat.sort_done = (pass_r >= n_r);
  assign stat.div_done = (dstep_r == '0);

  logic [SW-1:0] abs_sum;
  assign abs_sum = sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);

  logic [SW:0] trial;
  assign trial = {rem_r, quo_r[SW-1]} - {{(SW+1-CntW){1'b0}}, n_r};

  logic [IdxW-1:0] mid_hi, mid_lo;
  assign mid_hi = IdxW'(n_r >> 1);
  assign mid_lo = mid_hi - 1'b1;

  // finish stage arithmetic
  logic signed [26:0] med, mean, f, dma, fm, md;
  logic signed [26:0] mid_sum;
  logic [26:0] a_dma, a_fm, a_md;
  logic [31:0] dt;
  logic stable;
  logic close_hit;
  logic fill_ok;
  logic [7:0] close_inc;
  always_comb begin
    mid_sum = 27'(srt_r[mid_lo]) + 27'(srt_r[mid_hi]);
    if (n_r < CntW'(3)) begin
      med = '0;
    end else if (n_r[0]) begin
      med = 27'(srt_r[mid_hi]);
    end else begin
      med = (mid_sum + $signed({26'd0, mid_sum[26]})) >>> 1;
    end
    mean = neg_r ? -27'(quo_r) : 27'(quo_r);
    dma = med - mean;
    a_dma = dma[26] ? 27'(-dma) : 27'(dma);
    f = (a_dma < 27'(cfg.agree_band)) ? med : mean;
    if (f[26] || f < 27'(cfg.zero_band)) begin
      f = '0;
    end else if (f > 27'(cfg.max_weight)) begin
      f = 27'(cfg.max_weight);
    end
    fm = f_r - 27'(prev_r);
    a_fm = fm[26] ? 27'(-fm) : 27'(fm);
    dt = now_r - last_mt_r;
    md = med_r - 27'(last_stable_r);
    a_md = md[26] ? 27'(-md) : 27'(md);
    close_hit = a_md < 27'(cfg.settle_thr);
    close_inc = (close_r == 8'hFF) ? close_r : close_r + 1'b1;
    fill_ok = 8'(n_r) >= 8'(cfg.stable_count_required);
    stable = fill_ok && close_hit && (close_inc >= 8'(cfg.stable_count_required));
  end

  always_ff @(posedge clk) begin
    med_r <= med;
    f_r <= f;
    if (cmd.load) begin
      ring_r[widx_r] <= item.raw_weight;
      now_r <= item.now_ms;
      n_r <= n_new;
      for (int i = 0; i < RING_DEPTH; i++) begin
        srt_r[i] <= (IdxW'(i) == widx_r) ? item.raw_weight : ring_r[i];
      end
      sum_r <= '0;
    end else if (cmd.sort_step) begin
      srt_r <= srt_nxt;
      sum_r <= sum_r + SW'(ring_r[pass_r[IdxW-1:0]]);
    end
    if (cmd.div_start) begin
      neg_r <= sum_r[SW-1];
      quo_r <= abs_sum;
      rem_r <= '0;
      dstep_r <= DW'(SW);
    end else if (cmd.div_step) begin
      if (!trial[SW]) begin
        rem_r <= trial[SW-1:0];
        quo_r <= {quo_r[SW-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[SW-2:0], quo_r[SW-1]};
        quo_r <= {quo_r[SW-2:0], 1'b0};
      end
      dstep_r <= dstep_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      widx_r <= '0;
      ring_full_r <= 1'b0;
      close_r <= '0;
      last_stable_r <= '0;
      prev_r <= '0;
      last_mt_r <= '0;
      motion_r <= 1'b0;
      pass_r <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cmd.error || cmd.finish) begin
        res_valid <= 1'b1;
      end else if (res_taken) begin
        res_valid <= 1'b0;
      end
      if (cmd.load) begin
        pass_r <= '0;
        widx_r <= widx_inc;
        if (wrap) begin
          ring_full_r <= 1'b1;
        end
      end else if (cmd.sort_step) begin
        pass_r <= pass_r + 1'b1;
      end
      if (cmd.tare) begin
        widx_r <= '0;
        ring_full_r <= 1'b0;
        close_r <= '0;
        last_stable_r <= '0;
        motion_r <= 1'b0;
      end
      if (cmd.error) begin
        res.filtered_weight <= '0;
        res.stable_weight <= last_stable_r;
        res.is_stable <= 1'b0;
        res.has_motion <= 1'b0;
        res.quality <= lcwf_pkg::QualError;
      end
      if (cmd.finish) begin
        logic mflag;
        logic signed [24:0] ls;
        mflag = motion_r;
        ls = last_stable_r;
        if (a_fm > 27'(cfg.motion_thr)) begin
          last_mt_r <= now_r;
          mflag = 1'b1;
        end else if (dt > 32'(cfg.motion_hold_ms)) begin
          mflag = 1'b0;
        end
        motion_r <= mflag;
        prev_r <= 25'(f_r);
        if (fill_ok) begin
          if (close_hit) begin
            close_r <= close_inc;
          end else begin
            close_r <= '0;
            ls = 25'(med_r);
          end
        end
        if (stable) begin
          ls = 25'(f_r);
        end
        last_stable_r <= ls;
        res.filtered_weight <= 24'(f_r);
        res.stable_weight <= ls;
        res.is_stable <= stable;
        res.has_motion <= mflag;
        res.quality <= mflag ? lcwf_pkg::QualMotion :
                       (stable ? lcwf_pkg::QualStable : lcwf_pkg::QualStabilizing);
      end
    end
  end

  `LCWF_ASSERT(a_res_once, clk, rst_n, (cmd.finish |-> !(cmd.load || cmd.error)))
  `LCWF_ASSERT(a_fill, clk, rst_n, (n_r <= CntW'(RING_DEPTH) || !cmd.finish))
  `LCWF_ASSERT(a_tare_clr, clk, rst_n, (cmd.tare |=> (close_r == '0 && !motion_r)))
  `LCWF_ASSERT_RST(a_rst, clk, (!rst_n |=> !res_valid))

endmodule

// File: rtl/load_cell_weight_filter.sv
// Load cell weight filter.
// Input channel in_ch: one item per transfer (cmd, sample_valid, raw_weight,
// now_ms). Result channel out_ch: one result per weight sample, none for tare.
// Config channel cfg_ch: register index and data, always ready; write only
// while no item is in flight.
// A tare gives no result. For a not-ready sample the result is valid the
// cycle after the transfer.
// A weight sample with n filled entries, and SW = 25 + clog2(RING_DEPTH + 1),
// steps through the controller states in order: odd-even sort passes over
// the n entries while they are summed, a restoring divide for the mean at
// one bit per cycle over SW bits, a wait state that registers the filtered
// value, and a finish state that writes the result; the next input is taken
// once the block is back in idle.
// The result sits in an output register until taken; while it waits, no new
// input is accepted and a sample in flight holds before its finish cycle.
// Reset empties the ring, clears stability and motion state and loads the
// register defaults. Ring contents are not cleared; only written entries
// are read.
module load_cell_weight_filter #(
  parameter int unsigned RING_DEPTH = 10
) (
  input logic clk,
  input logic rst_n,
  lcwf_if.sink   in_ch,
  lcwf_if.sink   cfg_ch,
  lcwf_if.source out_ch
);

  lcwf_pkg::cfg_t cfg_r;
  lcwf_pkg::in_item_t item;
  lcwf_pkg::dp_cmd_t cmd;
  lcwf_pkg::dp_stat_t stat;
  lcwf_pkg::out_item_t res;
  logic res_valid;
  logic [2:0] cfg_idx;
  logic [23:0] cfg_wd;

  assign item = lcwf_pkg::in_item_t'(in_ch.data);
  assign cfg_ch.ready = 1'b1;
  assign cfg_idx = cfg_ch.data[26:24];
  assign cfg_wd = cfg_ch.data[23:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.motion_thr <= 20'd100;
      cfg_r.settle_thr <= 20'd50;
      cfg_r.stable_count_required <= 4'd5;
      cfg_r.zero_band <= 20'd20;
      cfg_r.max_weight <= 24'd10000000;
      cfg_r.motion_hold_ms <= 16'd2000;
      cfg_r.agree_band <= 20'd100;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx)
        lcwf_pkg::CfgMotionThr:  cfg_r.motion_thr <= cfg_wd[19:0];
        lcwf_pkg::CfgStableThr:  cfg_r.settle_thr <= cfg_wd[19:0];
        lcwf_pkg::CfgStableCnt:  cfg_r.stable_count_required <= cfg_wd[3:0];
        lcwf_pkg::CfgZeroBand:   cfg_r.zero_band <= cfg_wd[19:0];
        lcwf_pkg::CfgMaxWeight:  cfg_r.max_weight <= cfg_wd;
        lcwf_pkg::CfgMotionHold: cfg_r.motion_hold_ms <= cfg_wd[15:0];
        lcwf_pkg::CfgAgreeBand:  cfg_r.agree_band <= cfg_wd[19:0];
        default: ;
      endcase
    end
  end

  lcwf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_cmd(item.cmd), .in_sample_valid(item.sample_valid),
    .in_ready(in_ch.ready), .out_busy(res_valid && !out_ch.ready),
    .cmd(cmd), .stat(stat)
  );

  lcwf_dp #(.RING_DEPTH(RING_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg_r), .item(item), .cmd(cmd), .stat(stat),
    .res_valid(res_valid), .res(res), .res_taken(out_ch.ready)
  );

  assign out_ch.valid = res_valid;
  assign out_ch.data = res;

endmodule

// File: sim/load_cell_weight_filter_tb.sv
module load_cell_weight_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 10;
  localparam int CfgW = 27;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lcwf_if #(.W($bits(lcwf_pkg::in_item_t)))  in_ch();
  lcwf_if #(.W(CfgW))                        cfg_ch();
  lcwf_if #(.W($bits(lcwf_pkg::out_item_t))) out_ch();

  load_cell_weight_filter #(.RING_DEPTH(Depth)) uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .cfg_ch(cfg_ch.sink),
    .out_ch(out_ch.source)
  );

  always #4 clk = ~clk;

  lcwf_pkg::cfg_t regs;
  logic signed [24:0] ring [Depth];
  int unsigned ring_wr;
  bit ring_full;
  int unsigned close_cnt;
  logic signed [24:0] last_stable;
  logic signed [24:0] prev_filtered;
  logic [31:0] last_motion_ms;
  bit motion_on;

  lcwf_pkg::in_item_t pending_items[$];
  lcwf_pkg::out_item_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  bit in_gaps_on = 1'b1;
  bit out_gaps_on = 1'b1;
  int in_gap = 0;
  int out_gap = 0;
  int long_hold = 0;
  bit long_hold_done = 1'b0;
  logic [31:0] clock_ms = 32'd0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  function automatic longint iabs(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void reset_model();
    regs.motion_thr            = 20'd100;
    regs.settle_thr            = 20'd50;
    regs.stable_count_required = 4'd5;
    regs.zero_band             = 20'd20;
    regs.max_weight            = 24'd10000000;
    regs.motion_hold_ms        = 16'd2000;
    regs.agree_band            = 20'd100;
    foreach (ring[i]) ring[i] = '0;
    ring_wr = 0;
    ring_full = 0;
    close_cnt = 0;
    last_stable = '0;
    prev_filtered = '0;
    last_motion_ms = '0;
    motion_on = 0;
  endfunction

  function automatic void apply_reg(lcwf_pkg::cfg_idx_t idx, logic [23:0] v);
    case (idx)
      lcwf_pkg::CfgMotionThr:  regs.motion_thr            = v[19:0];
      lcwf_pkg::CfgStableThr:  regs.settle_thr            = v[19:0];
      lcwf_pkg::CfgStableCnt:  regs.stable_count_required = v[3:0];
      lcwf_pkg::CfgZeroBand:   regs.zero_band             = v[19:0];
      lcwf_pkg::CfgMaxWeight:  regs.max_weight            = v[23:0];
      lcwf_pkg::CfgMotionHold: regs.motion_hold_ms        = v[15:0];
      lcwf_pkg::CfgAgreeBand:  regs.agree_band            = v[19:0];
      default: ;
    endcase
  endfunction

  function automatic void filter_sample(lcwf_pkg::in_item_t it);
    lcwf_pkg::out_item_t res;
    longint vals[Depth];
    longint v, med, mean, f, sum;
    int unsigned n, j;
    bit stable;
    stable = 0;
    res = '0;
    if (it.cmd) begin
      ring_wr = 0;
      ring_full = 0;
      close_cnt = 0;
      last_stable = '0;
      motion_on = 0;
      return;
    end
    if (!it.sample_valid) begin
      res.stable_weight = last_stable;
      res.quality = lcwf_pkg::QualError;
      expected_results.push_back(res);
      return;
    end
    ring[ring_wr] = it.raw_weight;
    ring_wr++;
    if (ring_wr >= Depth) begin
      ring_wr = 0;
      ring_full = 1;
    end
    n = ring_full ? Depth : ring_wr;
    sum = 0;
    for (int i = 0; i < n; i++) begin
      v = ring[i];
      sum += v;
      j = i;
      while (j > 0 && vals[j-1] > v) begin
        vals[j] = vals[j-1];
        j--;
      end
      vals[j] = v;
    end
    if (n < 3) med = 0;
    else if (n % 2 == 0) med = (vals[n/2-1] + vals[n/2]) / 2;
    else med = vals[n/2];
    mean = sum / longint'(n);
    f = (iabs(med - mean) < longint'(regs.agree_band)) ? med : mean;
    if (f < 0 || f < longint'(regs.zero_band)) f = 0;
    else if (f > longint'(regs.max_weight)) f = regs.max_weight;

    if (iabs(f - longint'(prev_filtered)) > longint'(regs.motion_thr)) begin
      last_motion_ms = it.now_ms;
      motion_on = 1;
    end else if (32'(it.now_ms - last_motion_ms) > {16'd0, regs.motion_hold_ms}) begin
      motion_on = 0;
    end
    prev_filtered = 25'(f);

    if (n >= regs.stable_count_required) begin
      if (iabs(med - longint'(last_stable)) < longint'(regs.settle_thr)) begin
        if (close_cnt < 255) close_cnt++;
        if (close_cnt >= regs.stable_count_required) stable = 1;
      end else begin
        close_cnt = 0;
        last_stable = 25'(med);
      end
    end
    if (stable) last_stable = 25'(f);

    res.filtered_weight = 24'(f);
    res.stable_weight = last_stable;
    res.is_stable = stable;
    res.has_motion = motion_on;
    res.quality = motion_on ? lcwf_pkg::QualMotion :
                  (stable ? lcwf_pkg::QualStable : lcwf_pkg::QualStabilizing);
    expected_results.push_back(res);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) filter_sample(lcwf_pkg::in_item_t'(in_ch.data));
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_ch.data <= pending_items.pop_front();
        in_ch.valid <= 1'b1;
        in_gap <= in_gaps_on ? pick_gap() : 0;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    lcwf_pkg::out_item_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = lcwf_pkg::out_item_t'(out_ch.data);
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $time, got);
        end else begin
          want = expected_results.pop_front();
          if (got.filtered_weight !== want.filtered_weight) begin
            errors++;
            $display("%0t: filtered_weight expected %0d actual %0d", $time,
                     want.filtered_weight, got.filtered_weight);
          end
          if (got.stable_weight !== want.stable_weight) begin
            errors++;
            $display("%0t: stable_weight expected %0d actual %0d", $time,
                     want.stable_weight, got.stable_weight);
          end
          if (got.is_stable !== want.is_stable) begin
            errors++;
            $display("%0t: is_stable expected %0b actual %0b", $time,
                     want.is_stable, got.is_stable);
          end
          if (got.has_motion !== want.has_motion) begin
            errors++;
            $display("%0t: has_motion expected %0b actual %0b", $time,
                     want.has_motion, got.has_motion);
          end
          if (got.quality !== want.quality) begin
            errors++;
            $display("%0t: quality expected %0d actual %0d", $time,
                     want.quality, got.quality);
          end
        end
      end
      if (!long_hold_done && results_seen >= 300) begin
        long_hold_done <= 1'b1;
        long_hold <= 700;
        out_ch.ready <= 1'b0;
      end else if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        out_ch.ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        out_gap <= out_gaps_on ? pick_gap() : 0;
      end
    end
  end

  task automatic push_item(bit cmd, bit ok, int w);
    lcwf_pkg::in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) clock_ms = $urandom();
    else if (r < 5) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
    else clock_ms = clock_ms + $urandom_range(0, 400);
    it.cmd = cmd;
    it.sample_valid = ok;
    it.raw_weight = 25'(w);
    it.now_ms = clock_ms;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(lcwf_pkg::cfg_idx_t idx, logic [23:0] v);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= {idx, v};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    apply_reg(idx, v);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_all(int mt, int st, int sc, int zb, int mw, int mh, int ab);
    write_reg(lcwf_pkg::CfgMotionThr, 24'(mt));
    write_reg(lcwf_pkg::CfgStableThr, 24'(st));
    write_reg(lcwf_pkg::CfgStableCnt, 24'(sc));
    write_reg(lcwf_pkg::CfgZeroBand, 24'(zb));
    write_reg(lcwf_pkg::CfgMaxWeight, 24'(mw));
    write_reg(lcwf_pkg::CfgMotionHold, 24'(mh));
    write_reg(lcwf_pkg::CfgAgreeBand, 24'(ab));
  endtask

  task automatic random_phase(int count, int spread);
    int made, lvl, noise, r, run;
    made = 0;
    while (made < count) begin
      r = $urandom_range(0, 99);
      if (r < 5) lvl = -$urandom_range(0, 16777216);
      else if (r < 10) lvl = $urandom_range(16000000, 16777215);
      else lvl = $urandom_range(0, spread);
      noise = $urandom_range(0, 3) == 0 ? 400 : 30;
      run = $urandom_range(3, 16);
      for (int i = 0; i < run; i++) begin
        r = $urandom_range(0, 99);
        if (r < 3) push_item(1'b1, 1'($urandom_range(0, 1)), int'($urandom()));
        else if (r < 8) push_item(1'b0, 1'b0, int'($urandom()));
        else if (r < 11) push_item(1'b0, 1'b1, int'($urandom()));
        else push_item(1'b0, 1'b1, lvl + $urandom_range(0, 2 * noise) - noise);
        made++;
      end
    end
  endtask

  initial begin
    reset_model();
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    push_item(1'b0, 1'b0, 0);
    push_item(1'b0, 1'b1, 16777215);
    push_item(1'b0, 1'b1, -16777216);
    push_item(1'b0, 1'b1, 0);
    push_item(1'b0, 1'b1, 5);
    push_item(1'b1, 1'b0, 77);
    push_item(1'b0, 1'b1, 1000);
    push_item(1'b0, 1'b1, 1010);
    for (int i = 0; i < 11; i++) push_item(1'b0, 1'b1, 1000 + i);
    push_item(1'b0, 1'b0, -1);
    push_item(1'b1, 1'b1, 0);
    push_item(1'b0, 1'b1, -500);
    random_phase(360, 50000);
    wait_idle();

    write_all(0, 20'hFFFFF, 1, 0, 24'hFFFFFF, 0, 20'hFFFFF);
    in_gaps_on = 1'b0;
    random_phase(380, 16777215);
    wait_idle();

    write_all(20'hFFFFF, 0, 15, 20'hFFFFF, 0, 16'hFFFF, 0);
    in_gaps_on = 1'b1;
    out_gaps_on = 1'b0;
    random_phase(380, 2000000);
    wait_idle();

    write_all(50, 200, 3, 5, 500000, 100, 1000);
    out_gaps_on = 1'b1;
    random_phase(380, 600000);
    wait_idle();

    write_all(100, 50, 10, 20, 10000000, 2000, 100);
    random_phase(380, 100000);
    wait_idle();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
